// File: rtl/gmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmc_pkg
// shared types, codes and the exp lookup table of the mixture classifier
// ----------------------------------------------------------------------------
package gmc_pkg;

  localparam int MAX_CLASSES_DEF    = 16;
  localparam int MAX_COMPONENTS_DEF = 8;

  // 1/sqrt(2*pi) in q0.16
  localparam logic [14:0] INV_SQRT_2PI = 15'd26145;

  localparam int DIV_W   = 48;  // divisor and remainder width
  localparam int DIVN_W  = 49;  // numerator and quotient width
  localparam int STEP_W  = 6;

  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_TOTAL_ZERO   = 2'd1,
    STATUS_QUERY_UNUSED = 2'd2,
    STATUS_LOAD_REJECT  = 2'd3
  } status_e;

  typedef enum logic {
    CMD_LOAD     = 1'b0,
    CMD_CLASSIFY = 1'b1
  } command_e;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  rem;
    logic [DIVN_W-1:0] num;
    logic [DIV_W-1:0]  den;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIVN_W-1:0] quot;
  } div_rsp_t;

  typedef logic [16:0] exp_table_t [256];

  // exp(-k/16) in q0.16, built from a q0.32 recurrence
  function automatic exp_table_t build_exp_table();
    logic [127:0] p;
    exp_table_t   t;
    p = 128'd1 << 32;
    for (int k = 0; k < 256; k++) begin
      t[k] = 17'((p + 128'd32768) >> 16);
      p    = (p * 128'd4034748382 + (128'd1 << 31)) >> 32;
    end
    return t;
  endfunction

  localparam exp_table_t EXP_TABLE = build_exp_table();

endpackage

// File: rtl/gmc_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmc_divider
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module gmc_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gmc_pkg::div_req_t req_i,
  output gmc_pkg::div_rsp_t rsp_o
);

  logic [gmc_pkg::STEP_W-1:0] cnt_q;
  logic                       done_q;
  logic [gmc_pkg::DIV_W-1:0]  rem_q, den_q, rem_d;
  logic [gmc_pkg::DIVN_W-1:0] num_q, quot_q;
  logic [gmc_pkg::DIV_W:0]    trial;
  logic                       ge;

  always_comb begin
    trial = {rem_q, num_q[gmc_pkg::DIVN_W-1]};
    ge    = trial >= {1'b0, den_q};
    rem_d = ge ? gmc_pkg::DIV_W'(trial - {1'b0, den_q}) : trial[gmc_pkg::DIV_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        cnt_q <= req_i.steps;
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == gmc_pkg::STEP_W'(1)) done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.rem;
      num_q  <= req_i.num;
      den_q  <= req_i.den;
      quot_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q  <= rem_d;
      num_q  <= {num_q[gmc_pkg::DIVN_W-2:0], 1'b0};
      quot_q <= {quot_q[gmc_pkg::DIVN_W-2:0], ge};
    end
  end

  assign rsp_o.busy = cnt_q != '0;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

// File: rtl/gmc_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmc_store
// component memory, one write and one registered read port
// ----------------------------------------------------------------------------
module gmc_store #(
  parameter int DEPTH  = 128,
  parameter int DATA_W = 80
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/gaussian_mixture_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_mixture_classifier
// per-class gaussian mixture density classifier in fixed point
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid_i / in_ready_o) carries one item: a load writes one
//   mixture component, a classify scores a sample against all classes in use.
//   output channel (out_valid_o / out_ready_i) returns one result item per item.
//   config channel (cfg_valid_i / cfg_ready_o) writes class_count, always ready.
// flow
//   a load passes through ST_FIN into the output register.
//   a classify walks every loaded component of every class in use; each
//   component that is not cut off uses the shared divider for the 19-bit
//   normalized distance and the 49-bit density term. at the end the total is
//   normalized by right shifts and a 17-bit posterior divide follows.
//   one item is worked at a time; in_ready_o is high only while idle.
// reset
//   component counts clear and class_count returns to 1; the component memory
//   is left as is, since only entries below a class's count are ever read.
// stall
//   the result sits in an output register; a new item is taken while it waits,
//   and the next result holds back until the receiver takes the old one.
// ----------------------------------------------------------------------------
module gaussian_mixture_classifier #(
  parameter int MAX_CLASSES    = gmc_pkg::MAX_CLASSES_DEF,
  parameter int MAX_COMPONENTS = gmc_pkg::MAX_COMPONENTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // config
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [4:0]         cfg_data_i,
  // input items
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               command_i,
  input  logic [3:0]         class_index_i,
  input  logic [2:0]         component_index_i,
  input  logic [16:0]        weight_i,
  input  logic signed [31:0] mean_i,
  input  logic [30:0]        deviation_i,
  input  logic signed [31:0] sample_value_i,
  input  logic [3:0]         query_class_i,
  // result items
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [3:0]         best_class_o,
  output logic [16:0]        posterior_o,
  output logic [1:0]         status_o
);

  localparam int DEPTH  = MAX_CLASSES * MAX_COMPONENTS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CLS_W  = $clog2(MAX_CLASSES);
  localparam int CC_W   = $clog2(MAX_CLASSES + 1);
  localparam int CNT_W  = $clog2(MAX_COMPONENTS + 1);
  localparam int WORD_W = 17 + 32 + 31;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CLS, ST_RD, ST_CHK, ST_DIVZ, ST_SQ, ST_EX1, ST_EX2,
    ST_MW, ST_MC, ST_DIVT, ST_ACC, ST_CEND, ST_POST, ST_NORM, ST_DIVP, ST_FIN
  } state_e;

  state_e state_q;

  // config register, clamped to 1..MAX_CLASSES
  logic [CC_W-1:0] class_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_count_q <= CC_W'(1);
    end else if (cfg_valid_i) begin
      if (cfg_data_i == 5'd0)                  class_count_q <= CC_W'(1);
      else if (32'(cfg_data_i) > MAX_CLASSES)  class_count_q <= CC_W'(MAX_CLASSES);
      else                                     class_count_q <= CC_W'(cfg_data_i);
    end
  end

  assign cfg_ready_o = 1'b1;

  // accept and load checks
  logic in_acc, is_load, load_ok;
  logic [CNT_W-1:0] ccount_q [MAX_CLASSES];
  logic [CLS_W-1:0] cnt_raddr;
  logic [CNT_W-1:0] count_rd;
  logic [CC_W-1:0]  cls_q;
  logic [CNT_W-1:0] cmp_q;

  assign in_ready_o = state_q == ST_IDLE;
  assign in_acc     = in_valid_i && in_ready_o;
  assign is_load    = command_i == gmc_pkg::CMD_LOAD;

  // one count read port, shared by load check and classify walk
  assign cnt_raddr = (state_q == ST_IDLE) ? CLS_W'(class_index_i) : cls_q[CLS_W-1:0];
  assign count_rd  = ccount_q[cnt_raddr];

  always_comb begin
    load_ok = 1'b1;
    if (32'(class_index_i) >= MAX_CLASSES)        load_ok = 1'b0;
    if (32'(component_index_i) >= MAX_COMPONENTS) load_ok = 1'b0;
    if (weight_i > 17'd65536)                     load_ok = 1'b0;
    if (deviation_i == '0)                        load_ok = 1'b0;
    if (component_index_i != 3'd0 && 32'(component_index_i) != 32'(count_rd))
      load_ok = 1'b0;
  end

  logic mem_we;
  assign mem_we = in_acc && is_load && load_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CLASSES; i++) ccount_q[i] <= '0;
    end else if (mem_we) begin
      // component 0 restarts the class
      ccount_q[cnt_raddr] <= CNT_W'(32'(component_index_i) + 1);
    end
  end

  // component memory
  logic              mem_re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [WORD_W-1:0] rdata;

  assign waddr  = ADDR_W'(32'(class_index_i) * MAX_COMPONENTS + 32'(component_index_i));
  assign raddr  = ADDR_W'(32'(cls_q) * MAX_COMPONENTS + 32'(cmp_q));
  assign mem_re = (state_q == ST_CLS) && (32'(cmp_q) < 32'(count_rd));

  gmc_store #(
    .DEPTH  (DEPTH),
    .DATA_W (WORD_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wdata_i ({weight_i, mean_i, deviation_i}),
    .re_i    (mem_re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // shared divider
  gmc_pkg::div_req_t div_req_q;
  gmc_pkg::div_rsp_t div_rsp;

  gmc_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  // datapath registers
  logic signed [31:0] x_q;
  logic [3:0]         q_q;
  logic [CC_W-1:0]    n_q;
  logic [16:0]        w_q, a_q, ex_q;
  logic [30:0]        s_q;
  logic [32:0]        t_q;
  logic [18:0]        z_q;
  logic [20:0]        e_q;
  logic [28:0]        prod_q;
  logic [33:0]        wx_q;
  logic [63:0]        sum_q, maxsum_q, qsum_q, total_q;
  logic [3:0]         best_q;
  logic [3:0]         res_best_q;
  logic [16:0]        res_post_q;
  gmc_pkg::status_e   res_stat_q;
  logic               out_valid_q;
  logic [3:0]         out_best_q;
  logic [16:0]        out_post_q;
  gmc_pkg::status_e   out_stat_q;

  // combinational helpers
  logic signed [32:0] diff;
  logic [32:0]        t_abs;
  logic [37:0]        zsq;
  logic [7:0]         eidx;
  logic [16:0]        ta, tb;
  logic [29:0]        rnd;
  logic [63:0]        sum_new;

  always_comb begin
    diff    = 33'(x_q) - 33'($signed(rdata[62:31]));
    t_abs   = diff[32] ? 33'(-diff) : 33'(diff);
    zsq     = 38'(z_q) * 38'(z_q);
    eidx    = e_q[19:12];
    ta      = gmc_pkg::EXP_TABLE[eidx];
    tb      = (eidx != 8'hFF) ? gmc_pkg::EXP_TABLE[8'(eidx + 8'd1)] : 17'd0;
    rnd     = 30'(prod_q) + 30'd2048;
    sum_new = sum_q + 64'(div_rsp.quot);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      div_req_q   <= '0;
      out_valid_q <= 1'b0;
      out_best_q  <= '0;
      out_post_q  <= '0;
      out_stat_q  <= gmc_pkg::STATUS_OK;
      res_best_q  <= '0;
      res_post_q  <= '0;
      res_stat_q  <= gmc_pkg::STATUS_OK;
      x_q <= '0; q_q <= '0; n_q <= '0; cls_q <= '0; cmp_q <= '0;
      w_q <= '0; s_q <= '0; t_q <= '0; z_q <= '0; e_q <= '0;
      a_q <= '0; ex_q <= '0; prod_q <= '0; wx_q <= '0;
      sum_q <= '0; maxsum_q <= '0; qsum_q <= '0; total_q <= '0; best_q <= '0;
    end else begin
      // divider start pulses: distance, density term and posterior divides
      div_req_q.start <= (state_q == ST_CHK && 34'(t_q) < {s_q, 3'b000}) ||
                         (state_q == ST_MC) ||
                         (state_q == ST_NORM && total_q[63:47] == '0);
      if (state_q == ST_FIN && (!out_valid_q || out_ready_i)) out_valid_q <= 1'b1;
      else if (out_ready_i)                                   out_valid_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (is_load) begin
              res_best_q <= '0;
              res_post_q <= '0;
              res_stat_q <= load_ok ? gmc_pkg::STATUS_OK : gmc_pkg::STATUS_LOAD_REJECT;
              state_q    <= ST_FIN;
            end else begin
              x_q      <= sample_value_i;
              q_q      <= query_class_i;
              n_q      <= class_count_q;
              cls_q    <= '0;
              cmp_q    <= '0;
              sum_q    <= '0;
              maxsum_q <= '0;
              qsum_q   <= '0;
              total_q  <= '0;
              best_q   <= '0;
              state_q  <= ST_CLS;
            end
          end
        end
        ST_CLS: begin
          state_q <= mem_re ? ST_RD : ST_CEND;
        end
        ST_RD: begin
          w_q     <= rdata[79:63];
          s_q     <= rdata[30:0];
          t_q     <= t_abs;
          state_q <= ST_CHK;
        end
        ST_CHK: begin
          // z of 8.0 or more gives no density
          if (34'(t_q) >= {s_q, 3'b000}) begin
            state_q <= ST_ACC;
          end else begin
            div_req_q.rem   <= gmc_pkg::DIV_W'(t_q >> 3);
            div_req_q.num   <= {t_q[2:0], 16'd0, 30'd0};
            div_req_q.den   <= gmc_pkg::DIV_W'(s_q);
            div_req_q.steps <= gmc_pkg::STEP_W'(19);
            state_q         <= ST_DIVZ;
          end
        end
        ST_DIVZ: begin
          if (div_rsp.done) begin
            z_q     <= div_rsp.quot[18:0];
            state_q <= ST_SQ;
          end
        end
        ST_SQ: begin
          e_q     <= zsq[37:17];
          state_q <= ST_EX1;
        end
        ST_EX1: begin
          // exponent of 16 or more gives no density
          if (e_q[20]) begin
            state_q <= ST_ACC;
          end else begin
            a_q     <= ta;
            prod_q  <= 29'(ta - tb) * 29'(e_q[11:0]);
            state_q <= ST_EX2;
          end
        end
        ST_EX2: begin
          ex_q    <= a_q - 17'(rnd >> 12);
          state_q <= ST_MW;
        end
        ST_MW: begin
          wx_q    <= 34'(w_q) * 34'(ex_q);
          state_q <= ST_MC;
        end
        ST_MC: begin
          div_req_q.rem   <= '0;
          div_req_q.num   <= 49'(wx_q) * 49'(gmc_pkg::INV_SQRT_2PI);
          div_req_q.den   <= gmc_pkg::DIV_W'(s_q);
          div_req_q.steps <= gmc_pkg::STEP_W'(49);
          state_q         <= ST_DIVT;
        end
        ST_DIVT: begin
          if (div_rsp.done) begin
            sum_q   <= sum_new;
            cmp_q   <= cmp_q + 1'b1;
            state_q <= ST_CLS;
          end
        end
        ST_ACC: begin
          cmp_q   <= cmp_q + 1'b1;
          state_q <= ST_CLS;
        end
        ST_CEND: begin
          // strict compare keeps ties on the lower class
          if (cls_q == '0 || sum_q > maxsum_q) begin
            maxsum_q <= sum_q;
            best_q   <= 4'(cls_q);
          end
          if (32'(cls_q) == 32'(q_q)) qsum_q <= sum_q;
          total_q <= total_q + sum_q;
          sum_q   <= '0;
          cmp_q   <= '0;
          cls_q   <= cls_q + 1'b1;
          state_q <= (32'(cls_q) + 1 == 32'(n_q)) ? ST_POST : ST_CLS;
        end
        ST_POST: begin
          res_best_q <= best_q;
          res_post_q <= '0;
          if (32'(q_q) >= 32'(n_q)) begin
            res_stat_q <= gmc_pkg::STATUS_QUERY_UNUSED;
            state_q    <= ST_FIN;
          end else if (total_q == '0) begin
            res_stat_q <= gmc_pkg::STATUS_TOTAL_ZERO;
            state_q    <= ST_FIN;
          end else begin
            res_stat_q <= gmc_pkg::STATUS_OK;
            state_q    <= ST_NORM;
          end
        end
        ST_NORM: begin
          // bring the total below 2^47, one bit a cycle
          if (total_q[63:47] != '0) begin
            total_q <= total_q >> 1;
            qsum_q  <= qsum_q >> 1;
          end else begin
            div_req_q.rem   <= gmc_pkg::DIV_W'(qsum_q >> 1);
            div_req_q.num   <= {qsum_q[0], 16'd0, 32'd0};
            div_req_q.den   <= total_q[47:0];
            div_req_q.steps <= gmc_pkg::STEP_W'(17);
            state_q         <= ST_DIVP;
          end
        end
        ST_DIVP: begin
          if (div_rsp.done) begin
            res_post_q <= (div_rsp.quot > 49'd65536) ? 17'd65536 : div_rsp.quot[16:0];
            state_q    <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_best_q  <= res_best_q;
            out_post_q  <= res_post_q;
            out_stat_q  <= res_stat_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign best_class_o = out_best_q;
  assign posterior_o  = out_post_q;
  assign status_o     = out_stat_q;

  // flagged results carry no posterior
  a_flag_post: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != gmc_pkg::STATUS_OK |-> posterior_o == 17'd0)
    else $error("posterior nonzero on flagged result");

  a_post_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> posterior_o <= 17'd65536)
    else $error("posterior above one");

  a_cc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    class_count_q != '0 && 32'(class_count_q) <= MAX_CLASSES)
    else $error("class count out of range");

  a_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !div_rsp.busy)
    else $error("divider busy while idle");

  a_reject_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == gmc_pkg::STATUS_LOAD_REJECT |-> best_class_o == 4'd0)
    else $error("rejected load reports a class");

endmodule
